// File: rtl/chmc_pkg.sv
// Package for the monotone chain convex hull block.
// Types and widths for the hull block. No dependencies.
`timescale 1ns / 1ps
package chmc_pkg;
  localparam int MaxPoints  = 32;
  localparam int CoordBits  = 24;
  localparam int IdxBits    = $clog2(MaxPoints);
  localparam int CntBits    = $clog2(MaxPoints + 1);
  localparam int DiffBits   = CoordBits + 1;
  localparam int ProdBits   = 2 * DiffBits;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic [IdxBits-1:0]          idx_t;
  typedef logic [CntBits-1:0]          cnt_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;
endpackage

// File: rtl/chmc_if.sv
// Valid/ready channel interfaces for the hull block.
// Depends on chmc_pkg.
`timescale 1ns / 1ps
interface chmc_in_if import chmc_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t px;
  coord_t py;
  logic   final_point;
  modport source (output valid, px, py, final_point, input ready);
  modport sink   (input valid, px, py, final_point, output ready);
endinterface

interface chmc_out_if import chmc_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t hx;
  coord_t hy;
  logic   is_lower;
  logic   run_end;
  modport source (output valid, hx, hy, is_lower, run_end, input ready);
  modport sink   (input valid, hx, hy, is_lower, run_end, output ready);
endinterface

// File: rtl/chmc_turn.sv
// Strict left turn test with a registered multiply: (b-a) x (c-b) > 0, exact.
// Depends on chmc_pkg.
`timescale 1ns / 1ps
module chmc_turn import chmc_pkg::*; (
  input  logic   clk,
  input  point_t a,
  input  point_t b,
  input  point_t c,
  output logic   left
);
  logic signed [DiffBits-1:0] ex, ey, fx, fy;
  logic signed [ProdBits-1:0] p_r, q_r;
  logic signed [ProdBits:0]   d;

  assign ex = DiffBits'(b.x) - DiffBits'(a.x);
  assign ey = DiffBits'(b.y) - DiffBits'(a.y);
  assign fx = DiffBits'(c.x) - DiffBits'(b.x);
  assign fy = DiffBits'(c.y) - DiffBits'(b.y);

  // one multiplier each, registered, then the compare
  always_ff @(posedge clk) begin
    p_r <= ex * fy;
    q_r <= ey * fx;
  end

  assign d    = (ProdBits+1)'(p_r) - (ProdBits+1)'(q_r);
  assign left = (d > 0);
endmodule

// File: rtl/convex_hull_monotone_chain.sv
// Top level of the monotone chain convex hull block.
// Depends on chmc_pkg, chmc_if and chmc_turn.
`timescale 1ns / 1ps
// Usage:
//  - in channel: points sorted by ascending x, one transaction per point;
//    final_point marks the last point of a set. Points beyond 32 are dropped.
//  - out channel: upper hull vertices (increasing x, is_lower = 0), then
//    lower hull vertices (decreasing x, is_lower = 1); run_end on the last.
//  - Loading accepts points while in the load state. After the final point,
//    each scan handles a point in steps (store read, stack top read, stack
//    next read, registered multiply, decide and write back); a pop repeats
//    the stack reads and multiply, or goes straight back to decide when it
//    leaves fewer than two points. Emission moves one vertex per cycle while
//    out is ready, through a memory read and an output register.
//  - Input is not taken while a set is being processed or emitted.
//  - A stall on out holds the output register; the emit address waits.
//  - Reset (synchronous, active low) empties the point count and returns
//    to the load state; the memories are not cleared and need not be.
//  - The scan speed is set by the single read port of the stack memory and the
//    registered multiplier stage in the turn test.
module convex_hull_monotone_chain import chmc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  chmc_in_if.sink   in_ch,
  chmc_out_if.source out_ch
);
  typedef enum logic [6:0] {
    S_LOAD  = 7'b0000001,
    S_FETCH = 7'b0000010,  // read point i from the store and stack top (depth-1)
    S_TOPS  = 7'b0000100,  // latch point and stack top, read stack next (depth-2)
    S_NEXT  = 7'b0001000,  // latch stack next
    S_MUL   = 7'b0010000,  // wait for product register
    S_DEC   = 7'b0100000,  // pop or push
    S_EMIT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  point_t store_mem [MaxPoints];
  point_t stack_mem [2*MaxPoints]; // upper half 0..31, lower half 32..63

  cnt_t   count_r;
  cnt_t   i_r;              // scan position, counts points done
  logic   lower_r;          // which scan
  cnt_t   udepth_r, ldepth_r;
  point_t pnew_r, top_r, nxt_r;
  point_t store_q, stack_q;
  cnt_t   em_r;             // emit position within current hull
  logic   em_lower_r;
  logic   ov_r;             // output register full
  logic   rd_pend_r;        // stack read in flight for emit
  logic   rd_last_r, rd_lower_r;
  logic   left;

  cnt_t   depth;
  assign depth = lower_r ? ldepth_r : udepth_r;

  logic acc;
  assign in_ch.ready = (state_r == S_LOAD);
  assign acc = in_ch.valid & in_ch.ready;

  // store memory: write at load, read during scan
  idx_t sidx;
  assign sidx = lower_r ? IdxBits'(count_r - i_r - 1'b1) : IdxBits'(i_r);
  always_ff @(posedge clk) begin
    if (acc && count_r < cnt_t'(MaxPoints))
      store_mem[IdxBits'(count_r)] <= point_t'{x: in_ch.px, y: in_ch.py};
    store_q <= store_mem[sidx];
  end

  // stack memory: one read port, one write port
  // decide reads depth-2, which is the new top after a pop
  logic [IdxBits:0] st_raddr, st_waddr;
  logic             st_we;
  always_comb begin
    st_raddr = {lower_r, IdxBits'(depth - 1'b1)};
    if (state_r == S_TOPS || state_r == S_DEC)
      st_raddr = {lower_r, IdxBits'(depth - 2'd2)};
    if (state_r == S_EMIT) st_raddr = {em_lower_r, IdxBits'(em_r)};
  end
  assign st_waddr = {lower_r, IdxBits'(depth)};
  assign st_we = (state_r == S_DEC) && !(depth >= 2 && left) &&
                 depth < cnt_t'(MaxPoints);
  always_ff @(posedge clk) begin
    if (st_we) stack_mem[st_waddr] <= pnew_r;
    stack_q <= stack_mem[st_raddr];
  end

  chmc_turn u_turn (.clk(clk), .a(nxt_r), .b(top_r), .c(pnew_r), .left(left));

  // emit control
  cnt_t em_depth;
  logic em_go, out_free;
  assign em_depth = em_lower_r ? ldepth_r : udepth_r;
  assign out_free = !ov_r || out_ch.ready;
  // issue a read only when no earlier read is left waiting for the output slot
  assign em_go = (state_r == S_EMIT) && em_r < em_depth &&
                 !(rd_pend_r && ov_r && !out_ch.ready) && (!ov_r || out_ch.ready || !rd_pend_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD:  if (acc && in_ch.final_point) state_nxt = S_FETCH;
      S_FETCH: state_nxt = S_TOPS;  // store data lands during S_TOPS
      S_TOPS:  state_nxt = S_NEXT;
      S_NEXT:  state_nxt = S_MUL;
      S_MUL:   state_nxt = S_DEC;
      S_DEC: begin
        if (depth >= 2 && left) state_nxt = (depth - 1'b1 >= 2) ? S_TOPS : S_DEC;
        else if (i_r + 1'b1 < count_r) state_nxt = S_FETCH;
        else if (!lower_r) state_nxt = S_FETCH;
        else state_nxt = S_EMIT;
      end
      S_EMIT: if (em_lower_r && em_r >= em_depth && !rd_pend_r && !ov_r)
        state_nxt = S_LOAD;
      default: state_nxt = S_LOAD;
    endcase
  end

  // pop fallthrough when depth drops below 2 skips the test
  logic pop;
  assign pop = (state_r == S_DEC) && depth >= 2 && left;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      count_r    <= '0;
      i_r        <= '0;
      lower_r    <= 1'b0;
      udepth_r   <= '0;
      ldepth_r   <= '0;
      em_r       <= '0;
      em_lower_r <= 1'b0;
      ov_r       <= 1'b0;
      rd_pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (acc) begin
        if (count_r < cnt_t'(MaxPoints)) count_r <= count_r + 1'b1;
        if (in_ch.final_point) begin
          i_r <= '0; lower_r <= 1'b0; udepth_r <= '0; ldepth_r <= '0;
        end
      end
      if (state_r == S_DEC) begin
        if (pop) begin
          if (lower_r) ldepth_r <= ldepth_r - 1'b1;
          else         udepth_r <= udepth_r - 1'b1;
        end else begin
          if (depth < cnt_t'(MaxPoints)) begin
            if (lower_r) ldepth_r <= ldepth_r + 1'b1;
            else         udepth_r <= udepth_r + 1'b1;
          end
          if (i_r + 1'b1 < count_r) i_r <= i_r + 1'b1;
          else begin
            i_r <= '0;
            if (!lower_r) lower_r <= 1'b1;
            else begin em_r <= '0; em_lower_r <= 1'b0; end
          end
        end
      end
      // emit pipeline
      if (out_ch.valid && out_ch.ready) ov_r <= 1'b0;
      if (rd_pend_r && out_free) ov_r <= 1'b1;
      rd_pend_r <= 1'b0;
      if (rd_pend_r && !out_free) rd_pend_r <= 1'b1;
      if (state_r == S_EMIT) begin
        if (em_go && !(rd_pend_r && !out_free)) begin
          rd_pend_r <= 1'b1;
          em_r <= em_r + 1'b1;
        end else if (!em_lower_r && em_r >= em_depth) begin
          em_lower_r <= 1'b1;
          em_r <= '0;
        end
        if (state_nxt == S_LOAD) count_r <= '0;
      end
    end
  end

  // payload registers
  logic hold_q;
  point_t q_hold_r;
  always_ff @(posedge clk) begin
    if (state_r == S_TOPS)  pnew_r <= store_q;
    if (state_r == S_TOPS)  top_r  <= stack_q;
    if (state_r == S_NEXT)  nxt_r  <= stack_q;
    if (em_go && !(rd_pend_r && !out_free)) begin
      rd_lower_r <= em_lower_r;
      rd_last_r  <= em_lower_r && (em_r + 1'b1 == em_depth);
    end
    if (!rd_pend_r || out_free) hold_q <= 1'b0;
    if (rd_pend_r && !out_free && !hold_q) begin
      hold_q <= 1'b1; q_hold_r <= stack_q;
    end
    if (rd_pend_r && out_free) begin
      out_ch.hx       <= hold_q ? q_hold_r.x : stack_q.x;
      out_ch.hy       <= hold_q ? q_hold_r.y : stack_q.y;
      out_ch.is_lower <= rd_lower_r;
      out_ch.run_end  <= rd_last_r;
    end
  end
  assign out_ch.valid = ov_r;
endmodule
